// File: design/osr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osr_pkg
// Shared constants, types and the per-bin scoring function of the
// orientation spreading block.
// ----------------------------------------------------------------------------
package osr_pkg;

  localparam int DEF_MAX_SPREAD = 16;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // configuration register indexes
  localparam logic [1:0] CFG_SPREAD = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic [4:0]  RST_SPREAD = 5'd4;
  localparam logic [10:0] RST_WIDTH  = 11'd640;
  localparam logic [10:0] RST_HEIGHT = 11'd480;

  localparam logic [2:0] HIT_SCORE  = 3'd4;
  localparam logic [2:0] NEAR_SCORE = 3'd3;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  // 4 on a direct hit, 3 when a circular neighbour bin is set
  function automatic logic [2:0] bin_score(input logic [7:0] bits, input int k);
    logic [2:0] s;
    s = 3'd0;
    if (bits[k & 7]) begin
      s = HIT_SCORE;
    end else if (bits[(k + 1) & 7] || bits[(k + 7) & 7]) begin
      s = NEAR_SCORE;
    end
    return s;
  endfunction

endpackage

// File: design/osr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osr_cell
// One column slot of the horizontal window: holds the vertical OR of one
// column and hands it to the next cell on every shift.
// ----------------------------------------------------------------------------
module osr_cell
  import osr_pkg::*;
#(
  parameter int IDX = 0,
  parameter int TW  = 5
) (
  input  logic          clk,
  input  cell_ctl_t     ctl,
  input  logic [7:0]    din,
  input  logic [TW-1:0] span,
  output logic [7:0]    dout,
  output logic [7:0]    tap
);

  logic [7:0] col_bits;

  // at a row start every slot but the first drops the previous row
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      col_bits <= (ctl.clear && IDX != 0) ? 8'd0 : din;
    end
  end

  assign dout = col_bits;
  assign tap  = (IDX < int'(span)) ? col_bits : 8'd0;

endmodule

// File: design/osr_col_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osr_col_store
// Per-column row history: one word of the last rows' bytes per column,
// read on acceptance, ORed vertically and written back shifted by a row.
// ----------------------------------------------------------------------------
module osr_col_store
  import osr_pkg::*;
#(
  parameter int MAX_SPREAD = DEF_MAX_SPREAD,
  parameter int DEPTH      = DEF_MAX_WIDTH + DEF_MAX_SPREAD,
  parameter int AW         = $clog2(DEPTH),
  parameter int RW         = 11,
  parameter int TW         = $clog2(MAX_SPREAD + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] addr,
  input  logic [RW-1:0] row,
  input  logic [7:0]    bits,
  input  logic [TW-1:0] span,
  output logic [7:0]    col_or
);

  localparam int WORDW = 8 * MAX_SPREAD;

  logic [WORDW-1:0] mem [DEPTH];
  logic [WORDW-1:0] rd_data;
  logic             lw_valid;
  logic [AW-1:0]    lw_addr;
  logic [WORDW-1:0] lw_data;
  logic [WORDW-1:0] hist;
  logic [WORDW-1:0] new_word;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[addr] <= new_word;
    end
  end

  // the write of the previous beat lands at the edge of this beat's read
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (wr_en) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_addr <= addr;
      lw_data <= new_word;
    end
  end

  always_comb begin
    hist     = (lw_valid && lw_addr == addr) ? lw_data : rd_data;
    new_word = (hist << 8) | WORDW'(bits);
    col_or   = bits;
    // only rows of this frame and inside the window count
    for (int k = 1; k < MAX_SPREAD; k++) begin
      if (k < int'(span) && k <= int'(row)) begin
        col_or = col_or | hist[8*(k-1) +: 8];
      end
    end
  end

endmodule

// File: design/orientation_spread_response.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orientation_spread_response
// OR-spreads quantized orientations over a TxT window and scores each bin.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on pix_valid/pix_stall, one orientation per
// beat, over a frame of image_height+D rows by image_width+D columns where
// D = (T-1)/2. A beat is taken when valid is high and stall low.
// Each pixel at row and column of at least D yields one result beat on
// res_valid/res_stall: the spread byte, eight bin scores and frame_end on
// the last result of the frame. Result for a pixel passes the stage-1
// register, the window cells and stage 2, then the output register.
// Throughput is one pixel per clock while nothing stalls, set by the column
// history memory with one read and one write port, accessed once per column.
// Configuration beats on cfg_valid/cfg_ready (always ready) write spread
// size, width or height and restart the frame; write them only while idle.
// Reset restores T=4, 640x480 and restarts the frame; no memory clearing
// is needed, as history from earlier frames is masked by the row count.
// A stalled result holds; pixel beats still enter until one that yields a
// result waits behind it with one more beat behind that, then pix_stall rises.
// ----------------------------------------------------------------------------
module orientation_spread_response
  import osr_pkg::*;
#(
  parameter int MAX_SPREAD = DEF_MAX_SPREAD,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        pix_valid,
  output logic        pix_stall,
  input  logic [3:0]  orientation,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  spread_bits,
  output logic [2:0]  score_dir0,
  output logic [2:0]  score_dir1,
  output logic [2:0]  score_dir2,
  output logic [2:0]  score_dir3,
  output logic [2:0]  score_dir4,
  output logic [2:0]  score_dir5,
  output logic [2:0]  score_dir6,
  output logic [2:0]  score_dir7,
  output logic        frame_end
);

  localparam int DEPTH = MAX_WIDTH + MAX_SPREAD;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_HEIGHT + MAX_SPREAD);
  localparam int TW    = $clog2(MAX_SPREAD + 1);

  logic [4:0]    spread_size;
  logic [10:0]   image_width;
  logic [10:0]   image_height;

  logic [TW-1:0] t_len;
  logic [TW-1:0] d_len;
  logic [AW-1:0] w_len;
  logic [RW-1:0] h_len;
  logic [AW-1:0] col_limit;
  logic [RW-1:0] row_limit;

  logic [AW-1:0] col_count;
  logic [RW-1:0] row_count;

  logic          accept;
  logic          in_image;
  logic [7:0]    pix_bits;

  logic          s1_valid;
  logic [AW-1:0] s1_addr;
  logic [RW-1:0] s1_row;
  logic [7:0]    s1_bits;
  logic          s1_emit;
  logic          s1_last;
  logic          s1_row_start;
  logic          s1_move;

  logic          s2_valid;
  logic          s2_emit;
  logic          s2_last;
  logic          s2_move;
  logic          s2_free;
  logic          res_free;

  logic [7:0]    col_or;
  cell_ctl_t     cell_ctl;
  logic [7:0]    cell_out [MAX_SPREAD];
  logic [7:0]    cell_tap [MAX_SPREAD];
  logic [7:0]    spread_next;

  assign cfg_ready = 1'b1;

  // clamp the registers to their working ranges
  always_comb begin
    if (spread_size == 5'd0) begin
      t_len = TW'(1);
    end else if (int'(spread_size) > MAX_SPREAD) begin
      t_len = TW'(MAX_SPREAD);
    end else begin
      t_len = TW'(spread_size);
    end
    if (image_width == 11'd0) begin
      w_len = AW'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_len = AW'(MAX_WIDTH);
    end else begin
      w_len = AW'(image_width);
    end
    if (image_height == 11'd0) begin
      h_len = RW'(1);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      h_len = RW'(MAX_HEIGHT);
    end else begin
      h_len = RW'(image_height);
    end
    d_len     = (t_len - TW'(1)) >> 1;
    col_limit = w_len + AW'(d_len);
    row_limit = h_len + RW'(d_len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spread_size <= RST_SPREAD;
      image_width <= RST_WIDTH;
      image_height <= RST_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SPREAD: spread_size  <= cfg_data[4:0];
        CFG_WIDTH:  image_width  <= cfg_data;
        CFG_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign res_free  = !res_valid || !res_stall;
  assign s2_move   = s2_valid && (!s2_emit || res_free);
  assign s2_free   = !s2_valid || s2_move;
  assign s1_move   = s1_valid && s2_free;
  assign pix_stall = s1_valid && !s2_free;
  assign accept    = pix_valid && !pix_stall;

  assign in_image = (row_count < h_len) && (col_count < w_len);
  assign pix_bits = (orientation >= 4'd1 && orientation <= 4'd8 && in_image)
                    ? (8'd1 << (orientation - 4'd1)) : 8'd0;

  // frame position; a configuration write to spread, width or height restarts the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cfg_valid && (cfg_index == CFG_SPREAD || cfg_index == CFG_WIDTH ||
                               cfg_index == CFG_HEIGHT)) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_count == col_limit - AW'(1)) begin
        col_count <= '0;
        row_count <= (row_count == row_limit - RW'(1)) ? '0 : row_count + RW'(1);
      end else begin
        col_count <= col_count + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr      <= col_count;
      s1_row       <= row_count;
      s1_bits      <= pix_bits;
      s1_emit      <= (row_count >= RW'(d_len)) && (col_count >= AW'(d_len));
      s1_last      <= (row_count == row_limit - RW'(1)) &&
                      (col_count == col_limit - AW'(1));
      s1_row_start <= (col_count == '0);
    end
  end

  osr_col_store #(
    .MAX_SPREAD (MAX_SPREAD),
    .DEPTH      (DEPTH),
    .AW         (AW),
    .RW         (RW),
    .TW         (TW)
  ) u_col_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (col_count),
    .wr_en   (s1_move),
    .addr    (s1_addr),
    .row     (s1_row),
    .bits    (s1_bits),
    .span    (t_len),
    .col_or  (col_or)
  );

  assign cell_ctl.shift = s1_move;
  assign cell_ctl.clear = s1_row_start;

  for (genvar j = 0; j < MAX_SPREAD; j++) begin : g_cell
    osr_cell #(
      .IDX (j),
      .TW  (TW)
    ) u_cell (
      .clk  (clk),
      .ctl  (cell_ctl),
      .din  ((j == 0) ? col_or : cell_out[(j == 0) ? 0 : j - 1]),
      .span (t_len),
      .dout (cell_out[j]),
      .tap  (cell_tap[j])
    );
  end

  always_comb begin
    spread_next = 8'd0;
    for (int j = 0; j < MAX_SPREAD; j++) begin
      spread_next = spread_next | cell_tap[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_emit <= s1_emit;
      s2_last <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s2_move && s2_emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move && s2_emit) begin
      spread_bits <= spread_next;
      score_dir0  <= bin_score(spread_next, 0);
      score_dir1  <= bin_score(spread_next, 1);
      score_dir2  <= bin_score(spread_next, 2);
      score_dir3  <= bin_score(spread_next, 3);
      score_dir4  <= bin_score(spread_next, 4);
      score_dir5  <= bin_score(spread_next, 5);
      score_dir6  <= bin_score(spread_next, 6);
      score_dir7  <= bin_score(spread_next, 7);
      frame_end   <= s2_last;
    end
  end

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col_count < col_limit)
    else $error("column count beyond frame width");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row_count < row_limit)
    else $error("row count beyond frame height");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_addr))
    else $error("held column beat lost or changed");

  a_score_hit: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((score_dir0 == HIT_SCORE) == spread_bits[0]))
    else $error("bin score disagrees with spread byte");

endmodule

// File: dv/tb_orientation_spread_response.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_orientation_spread_response
// Self-checking bench for the orientation spreading and bin scoring block.
// ----------------------------------------------------------------------------
// Frames of quantized orientations go in as beats in random bursts with random
// gaps. The result side stalls on a pattern of its own. A model in the bench
// keeps its own line history and frame position, ORs the window for every
// pixel that yields a result, grades the eight bins and queues the expected
// beat. Each result beat is then compared field by field with the oldest
// queued beat. The sweep covers the reset setting, every orientation code,
// spread sizes from zero to saturation, zero and tiny image sizes, frame
// restarts on register writes, back-to-back frames and small random frames,
// some of them broken off part way.
// ----------------------------------------------------------------------------
module tb_orientation_spread_response;
  import osr_pkg::*;

  localparam int LINE_COLS = DEF_MAX_WIDTH + DEF_MAX_SPREAD;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_PIXELS = 150;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam logic [2:0] NO_SCORE = 3'd0;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  typedef struct packed {
    logic [7:0]      spread;
    logic [7:0][2:0] score;
    logic            last;
  } spread_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;
  logic        pix_valid = 1'b0;
  logic        pix_stall;
  logic [3:0]  orientation = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [7:0]  spread_bits;
  logic [2:0]  score_dir0;
  logic [2:0]  score_dir1;
  logic [2:0]  score_dir2;
  logic [2:0]  score_dir3;
  logic [2:0]  score_dir4;
  logic [2:0]  score_dir5;
  logic [2:0]  score_dir6;
  logic [2:0]  score_dir7;
  logic        frame_end;

  orientation_spread_response u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .orientation(orientation),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .spread_bits(spread_bits),
    .score_dir0 (score_dir0),
    .score_dir1 (score_dir1),
    .score_dir2 (score_dir2),
    .score_dir3 (score_dir3),
    .score_dir4 (score_dir4),
    .score_dir5 (score_dir5),
    .score_dir6 (score_dir6),
    .score_dir7 (score_dir7),
    .frame_end  (frame_end)
  );

  always #6 clk = ~clk;

  // model state
  bit [7:0]     line_hist [DEF_MAX_SPREAD][LINE_COLS];
  bit [4:0]     reg_spread;
  bit [10:0]    reg_width;
  bit [10:0]    reg_height;
  int unsigned  row_pos;
  int unsigned  col_pos;
  spread_beat_t pending_spreads[$];

  int          error_count;
  int unsigned pixels_sent;
  int unsigned results_checked;
  int unsigned frames_seen;
  int unsigned cfg_writes;
  int          burst_left;
  bit          steady;
  stall_mode_t stall_mode;
  int          stall_phase;

  function automatic int unsigned effective_size(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [2:0] bin_grade(input logic [7:0] bits, input int k);
    if (bits[k]) return HIT_SCORE;
    if (bits[(k + 1) % 8] || bits[(k + 7) % 8]) return NEAR_SCORE;
    return NO_SCORE;
  endfunction

  // Store the pixel's bit, then OR the window that ends at it and queue a beat
  // once the pixel lies D or more rows and columns into the extended frame.
  function automatic void predict_spread(input logic [3:0] ori);
    int unsigned  t, d, w, h, r, c, k, j;
    logic [7:0]   acc;
    spread_beat_t beat;
    t = effective_size(reg_spread, DEF_MAX_SPREAD);
    d = t - 1 - t / 2;
    w = effective_size(reg_width, DEF_MAX_WIDTH);
    h = effective_size(reg_height, DEF_MAX_HEIGHT);
    if (col_pos >= w + d) col_pos = 0;
    if (row_pos >= h + d) row_pos = 0;
    r = row_pos;
    c = col_pos;
    if (ori >= 1 && ori <= 8 && r < h && c < w) begin
      line_hist[r % DEF_MAX_SPREAD][c] = 8'd1 << (ori - 1);
    end else begin
      line_hist[r % DEF_MAX_SPREAD][c] = 8'd0;
    end
    if (r >= d && c >= d) begin
      acc = '0;
      for (k = 0; k < t && k <= r; k++) begin
        for (j = 0; j < t && j <= c; j++) begin
          acc |= line_hist[(r - k) % DEF_MAX_SPREAD][c - j];
        end
      end
      beat.spread = acc;
      for (k = 0; k < 8; k++) begin
        beat.score[k] = bin_grade(acc, k);
      end
      beat.last = (r == h + d - 1) && (c == w + d - 1);
      pending_spreads.push_back(beat);
    end
    col_pos = c + 1;
    if (col_pos >= w + d) begin
      col_pos = 0;
      row_pos = r + 1;
      if (row_pos >= h + d) row_pos = 0;
    end
  endfunction

  function automatic int unsigned frame_pixels(input logic [10:0] spread, width, height);
    int unsigned t, d;
    t = effective_size(spread[4:0], DEF_MAX_SPREAD);
    d = t - 1 - t / 2;
    return (effective_size(height, DEF_MAX_HEIGHT) + d) *
           (effective_size(width, DEF_MAX_WIDTH) + d);
  endfunction

  function automatic logic [3:0] random_orientation();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 4'd0;
    if (pick < 95) return 4'($urandom_range(1, 8));
    return 4'($urandom_range(9, 15));
  endfunction

  // register writes, pixel beats and result beats, all seen before the edge
  always @(posedge clk) begin : monitor
    spread_beat_t seen;
    spread_beat_t want;
    if (rst) begin
      reg_spread = RST_SPREAD;
      reg_width  = RST_WIDTH;
      reg_height = RST_HEIGHT;
      row_pos    = 0;
      col_pos    = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SPREAD: reg_spread = cfg_data[4:0];
          CFG_WIDTH:  reg_width  = cfg_data;
          CFG_HEIGHT: reg_height = cfg_data;
          default: ;
        endcase
        // a known register restarts the frame
        if (cfg_index != CFG_UNUSED) begin
          row_pos = 0;
          col_pos = 0;
        end
      end
      if (pix_valid && !pix_stall) predict_spread(orientation);
      if (res_valid && !res_stall) begin
        seen.spread = spread_bits;
        seen.score  = {score_dir7, score_dir6, score_dir5, score_dir4,
                       score_dir3, score_dir2, score_dir1, score_dir0};
        seen.last   = frame_end;
        if (pending_spreads.size() == 0) begin
          error_count++;
          $error("result beat with nothing expected: spread_bits %02h", spread_bits);
        end else begin
          want = pending_spreads.pop_front();
          results_checked++;
          if (seen.last) frames_seen++;
          if (seen.spread !== want.spread) begin
            error_count++;
            $error("spread_bits: expected %02h, got %02h", want.spread, seen.spread);
          end
          for (int k = 0; k < 8; k++) begin
            if (seen.score[k] !== want.score[k]) begin
              error_count++;
              $error("score_dir%0d: expected %0d, got %0d", k, want.score[k], seen.score[k]);
            end
          end
          if (seen.last !== want.last) begin
            error_count++;
            $error("frame_end: expected %0b, got %0b", want.last, seen.last);
          end
        end
      end
    end
  end

  // receiver: switch between free flow, light, heavy and periodic stalling
  always @(negedge clk) begin
    if (stall_phase == 0) begin
      stall_mode  = stall_mode_t'($urandom_range(0, 3));
      stall_phase = $urandom_range(16, 96);
    end
    stall_phase--;
    case (stall_mode)
      STALL_NONE:  res_stall <= 1'b0;
      STALL_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: res_stall <= ($urandom_range(0, 3) != 0);
      default:     res_stall <= (stall_phase % 7 < 3);
    endcase
  end

  // Entered and left at a falling edge. Valid stays high while the burst
  // lasts, so consecutive beats need no extra step.
  task automatic send_pixel(input logic [3:0] ori);
    int gap;
    if (burst_left == 0) begin
      gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
      if (gap > 0) begin
        pix_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    pix_valid   <= 1'b1;
    orientation <= ori;
    do @(posedge clk); while (pix_stall);
    burst_left--;
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int unsigned n);
    repeat (n) send_pixel(random_orientation());
  endtask

  // drop valid, wait for every queued beat, then let trailing pixels clear
  task automatic settle();
    pix_valid <= 1'b0;
    burst_left = 0;
    while (pending_spreads.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] val, input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_writes++;
    @(negedge clk);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [10:0] spread, width, height);
    write_reg(CFG_SPREAD, spread, 1'b0);
    write_reg(CFG_WIDTH, width, 1'b0);
    write_reg(CFG_HEIGHT, height, 1'b1);
  endtask

  task automatic run_frames(input logic [10:0] spread, width, height, input int unsigned n);
    settle();
    configure(spread, width, height);
    send_random(frame_pixels(spread, width, height) * n);
  endtask

  // T=4 on a 640-wide frame: a whole row 0, then the start of row 1 yields results
  task automatic test_reset_setting();
    send_random(RST_WIDTH + 9);
  endtask

  // single-pixel window: each code shows up alone, wrap-round neighbours too
  task automatic test_orientation_codes();
    settle();
    configure(11'd1, 11'd16, 11'd1);
    for (int o = 0; o < 16; o++) begin
      send_pixel(4'(o));
    end
  endtask

  task automatic test_spread_sizes();
    run_frames(11'd0, 11'd5, 11'd3, 1);
    run_frames(11'd2, 11'd5, 11'd3, 1);
    run_frames(11'd16, 11'd3, 11'd2, 1);
    run_frames(11'd17, 11'd1, 11'd1, 1);
    // upper data bits are dropped by the spread register
    run_frames(11'h7E1, 11'd6, 11'd2, 1);
  endtask

  task automatic test_image_sizes();
    run_frames(11'd1, 11'd0, 11'd0, 2);
    run_frames(11'd3, 11'd2, 11'd1, 1);
    run_frames(11'd2, 11'd1, 11'd3, 1);
  endtask

  task automatic test_frame_restart();
    settle();
    configure(11'd3, 11'd6, 11'd4);
    send_random(15);
    settle();
    // rewrite the same width: the frame starts over
    write_reg(CFG_WIDTH, 11'd6, 1'b1);
    send_random(frame_pixels(11'd3, 11'd6, 11'd4));
    send_random(10);
    settle();
    // unused index: the frame carries on where it stopped
    write_reg(CFG_UNUSED, 11'h7FF, 1'b1);
    send_random(frame_pixels(11'd3, 11'd6, 11'd4) - 10);
  endtask

  task automatic test_continuous_frames();
    steady = 1'b1;
    run_frames(11'd4, 11'd5, 11'd3, 2);
    run_frames(11'd1, 11'd9, 11'd3, 2);
    steady = 1'b0;
  endtask

  task automatic test_random_frames();
    int unsigned start, t, w, h, n, budget;
    logic [5:0]  junk;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      steady = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 4) == 0) begin
        t = $urandom_range(0, 31);
        w = $urandom_range(0, 6);
        h = $urandom_range(0, 6);
      end else begin
        t = $urandom_range(1, 6);
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 6);
      end
      junk = 6'($urandom_range(0, 63));
      settle();
      configure({junk, t[4:0]}, 11'(w), 11'(h));
      n = frame_pixels({junk, t[4:0]}, 11'(w), 11'(h)) * $urandom_range(1, 3);
      // break off mid-frame now and then
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      budget = RANDOM_PIXELS - (pixels_sent - start);
      if (n > budget) n = budget;
      send_random(n);
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_setting();
    test_orientation_codes();
    test_spread_sizes();
    test_image_sizes();
    test_frame_restart();
    test_continuous_frames();
    test_random_frames();
    settle();
    $display("%0d pixel beats sent, %0d result beats checked, %0d frame ends, %0d writes",
             pixels_sent, results_checked, frames_seen, cfg_writes);
    $display("window sides 1 to 16 incl. saturation, default and tiny images, restarts");
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
design/osr_pkg.sv
design/osr_cell.sv
design/osr_col_store.sv
design/orientation_spread_response.sv
dv/tb_orientation_spread_response.sv
